>>> src/dpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types and constants for the duplicate packet filter.
// ----------------------------------------------------------------------------
package dpf_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 16;

  localparam logic [31:0] SWEEP_INTERVAL_RST = 32'd300000;
  localparam logic [31:0] ENTRY_TIMEOUT_RST  = 32'd30000;
  localparam logic [15:0] DUP_WINDOW_RST     = 16'd5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_WINDOW     = 2'd2;

  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [31:0] sweep_interval_ms;
    logic [31:0] entry_timeout_ms;
    logic [15:0] dup_window;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_ms;
    logic [31:0] src_address;
    logic [15:0] stream_handle;
    logic [15:0] seq_number;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] handle;
    logic [15:0] seq;
    logic [31:0] seen_time;
  } row_t;

  typedef struct packed {
    logic valid;
    logic is_duplicate;
    logic table_full;
  } res_t;

endpackage

>>> src/dpf_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_row_mem
// Row storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dpf_row_mem
  import dpf_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_TABLE_ENTRIES,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  row_t             wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output row_t             rd_data
);

  row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/dpf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_ctrl
// Row scan sequencer: lookup, free row search, aging sweep and write-back.
// ----------------------------------------------------------------------------
module dpf_ctrl
  import dpf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_req,
  input  cfg_t             cfg,
  input  logic             res_ready,
  output res_t             res,
  output logic             mem_wr_en,
  output logic [IDX_W-1:0] mem_wr_addr,
  output row_t             mem_wr_data,
  output logic             mem_rd_en,
  output logic [IDX_W-1:0] mem_rd_addr,
  input  row_t             mem_rd_data
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

  state_t                   state_r, state_nxt;
  req_t                     req_r, req_nxt;
  logic [31:0]              last_sweep_r, last_sweep_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]         issue_cnt_r, issue_cnt_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]         chk_idx_r, chk_idx_nxt;
  logic                     hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic [15:0]              hit_seq_r, hit_seq_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;

  logic        sweep_due;
  logic        row_live;
  logic        row_match;
  logic        row_stale;
  logic        dup;
  logic [15:0] seq_diff;

  assign sweep_due = (in_req.now_ms - last_sweep_r) > cfg.sweep_interval_ms;
  assign row_live  = valid_r[chk_idx_r];
  assign row_match = (mem_rd_data.address == req_r.src_address) &&
                     (mem_rd_data.handle == req_r.stream_handle);
  assign row_stale = (req_r.now_ms - mem_rd_data.seen_time) > cfg.entry_timeout_ms;

  assign seq_diff = hit_seq_r - req_r.seq_number;
  assign dup      = (req_r.seq_number == hit_seq_r) ||
                    ((req_r.seq_number < hit_seq_r) && (seq_diff < cfg.dup_window));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && ((in_req.req_type == REQ_CHECK) || sweep_due)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_cnt_r == LAST_CNT) begin
          state_nxt = (req_r.req_type == REQ_TICK) ? ST_IDLE : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    mem_rd_en        = (state_r == ST_SCAN) && (issue_cnt_r < LAST_CNT);
    mem_rd_addr      = issue_cnt_r[IDX_W-1:0];
    res.valid        = (state_r == ST_UPDATE);
    res.is_duplicate = hit_found_r && dup;
    res.table_full   = !hit_found_r && !free_found_r;
    mem_wr_en        = (state_r == ST_UPDATE) && res_ready && (hit_found_r || free_found_r);
    mem_wr_addr      = hit_found_r ? hit_idx_r : free_idx_r;
    mem_wr_data.address   = req_r.src_address;
    mem_wr_data.handle    = req_r.stream_handle;
    mem_wr_data.seq       = (hit_found_r && dup) ? hit_seq_r : req_r.seq_number;
    mem_wr_data.seen_time = req_r.now_ms;
  end

  // datapath
  always_comb begin
    req_nxt        = req_r;
    last_sweep_nxt = last_sweep_r;
    valid_nxt      = valid_r;
    issue_cnt_nxt  = issue_cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_seq_nxt    = hit_seq_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_req;
          issue_cnt_nxt  = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          if ((in_req.req_type == REQ_TICK) && sweep_due) begin
            last_sweep_nxt = in_req.now_ms;
          end
        end
      end
      ST_SCAN: begin
        if (mem_rd_en) begin
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = mem_rd_addr;
        end
        if (chk_vld_r) begin
          if (req_r.req_type == REQ_TICK) begin
            if (row_live && row_stale) begin
              valid_nxt[chk_idx_r] = 1'b0;
            end
          end else if (row_live) begin
            if (!hit_found_r && row_match) begin
              hit_found_nxt = 1'b1;
              hit_idx_nxt   = chk_idx_r;
              hit_seq_nxt   = mem_rd_data.seq;
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
        end
      end
      ST_UPDATE: begin
        if (res_ready && !hit_found_r && free_found_r) begin
          valid_nxt[free_idx_r] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_sweep_r <= '0;
      valid_r      <= '0;
      chk_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_sweep_r <= last_sweep_nxt;
      valid_r      <= valid_nxt;
      chk_vld_r    <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    issue_cnt_r  <= issue_cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_seq_r    <= hit_seq_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
  end

endmodule

>>> src/duplicate_packet_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_packet_filter
// Sequence number duplicate detection cache keyed by source and handle.
// ----------------------------------------------------------------------------
// A packet transfer (tuser 0) reads every row once, one per cycle, through
// the single read port of the row memory; read data is registered and each
// row is checked in the cycle after its read. The matched or free row is
// written back, and the block returns to idle, when the result is taken into
// the output register. A tick transfer (tuser 1) that starts a sweep occupies
// the block until every row has been read and checked; a tick that does not
// start one leaves the block idle. Ticks give no output transfer. The next
// input transfer is taken as soon as the block is idle, while the previous
// result may still wait in the output register. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module duplicate_packet_filter
  import dpf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_ms[31:0], src_address[63:32], stream_handle[79:64], seq_number[95:80]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // is_duplicate[0], table_full[1], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_dup_r, out_dup_nxt;
  logic out_full_r, out_full_nxt;

  req_t             in_req;
  res_t             res;
  logic             res_ready;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  row_t             mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  row_t             mem_rd_data;

  assign in_req.req_type      = in_tuser;
  assign in_req.now_ms        = in_tdata[31:0];
  assign in_req.src_address   = in_tdata[63:32];
  assign in_req.stream_handle = in_tdata[79:64];
  assign in_req.seq_number    = in_tdata[95:80];

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SWEEP_INTERVAL: cfg_nxt.sweep_interval_ms = cfg_data;
        CFG_ENTRY_TIMEOUT:  cfg_nxt.entry_timeout_ms  = cfg_data;
        CFG_DUP_WINDOW:     cfg_nxt.dup_window        = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_dup_nxt   = out_dup_r;
    out_full_nxt  = out_full_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_dup_nxt   = res.is_duplicate;
      out_full_nxt  = res.table_full;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sweep_interval_ms <= SWEEP_INTERVAL_RST;
      cfg_r.entry_timeout_ms  <= ENTRY_TIMEOUT_RST;
      cfg_r.dup_window        <= DUP_WINDOW_RST;
      out_valid_r             <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dup_r  <= out_dup_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2){1'b0}}, out_full_r, out_dup_r};

  dpf_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req      (in_req),
    .cfg         (cfg_r),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  dpf_row_mem #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
